// ===== design/i2cbe_pkg.sv =====
// Shared types, constants and helpers for the I2C master bit engine.
package i2cbe_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int CMD_W         = 3;
  localparam int IDX_W         = 5;
  localparam int BYTE_W        = BITS_PER_BYTE;
  localparam int SH_W          = $clog2(BITS_PER_BYTE);

  typedef enum logic [CMD_W-1:0] {
    CMD_IDLE   = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_RDACK  = 3'd4,
    CMD_READ   = 3'd5,
    CMD_SNDACK = 3'd6
  } cmd_t;

  // One period after decode: command (idle when none) plus its side data.
  typedef struct packed {
    cmd_t              cmd;
    logic              is_cmd;
    logic [BYTE_W-1:0] tx_byte;
    logic              ack_to_send;
    logic              sda_in;
  } fe_item_t;

  function automatic logic [IDX_W-1:0] cmd_len(input cmd_t c);
    logic [IDX_W-1:0] len;
    case (c)
      CMD_START:  len = IDX_W'(3);
      CMD_STOP:   len = IDX_W'(3);
      CMD_WRITE:  len = IDX_W'(2 * BITS_PER_BYTE + 1);
      CMD_RDACK:  len = IDX_W'(2);
      CMD_READ:   len = IDX_W'(2 * BITS_PER_BYTE + 1);
      CMD_SNDACK: len = IDX_W'(4);
      default:    len = IDX_W'(1);
    endcase
    return len;
  endfunction

endpackage

// ===== design/i2cbe_if.sv =====
// Valid/ready channel interfaces for the I2C master bit engine.
interface i2cbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] tx_byte;
  logic       ack_to_send;
  logic       sda_in;

  modport source (output valid, action, tx_byte, ack_to_send, sda_in, input ready);
  modport sink   (input valid, action, tx_byte, ack_to_send, sda_in, output ready);
endinterface

interface i2cbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;
  logic       rejected;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_seen, rejected, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_seen, rejected, output ready);
endinterface

// ===== design/i2cbe_front.sv =====
// Front end: accept a period request and decode its action into a command.
module i2cbe_front (
  i2cbe_in_if.sink              in_ch,
  output logic                  push,
  output i2cbe_pkg::fe_item_t   push_item,
  input  logic                  full
);

  i2cbe_pkg::cmd_t cmd;

  always_comb begin
    unique case (in_ch.action) inside
      i2cbe_pkg::CMD_START, i2cbe_pkg::CMD_STOP, i2cbe_pkg::CMD_WRITE,
      i2cbe_pkg::CMD_RDACK, i2cbe_pkg::CMD_READ, i2cbe_pkg::CMD_SNDACK: begin
        cmd = i2cbe_pkg::cmd_t'(in_ch.action);
      end
      // none and the unused code both mean no command
      default: begin
        cmd = i2cbe_pkg::CMD_IDLE;
      end
    endcase
  end

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  always_comb begin
    push_item.cmd         = cmd;
    push_item.is_cmd      = (cmd != i2cbe_pkg::CMD_IDLE);
    push_item.tx_byte     = in_ch.tx_byte;
    push_item.ack_to_send = in_ch.ack_to_send;
    push_item.sda_in      = in_ch.sda_in;
  end

endmodule

// ===== design/i2cbe_queue.sv =====
// Two-entry request queue between the decoder and the bus sequencer.
module i2cbe_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  i2cbe_pkg::fe_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output i2cbe_pkg::fe_item_t pop_item
);

  i2cbe_pkg::fe_item_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== design/i2cbe_back.sv =====
// Back end: run the bus period sequencer and register one result per period.
module i2cbe_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                not_empty,
  input  i2cbe_pkg::fe_item_t item,
  output logic                pop,
  i2cbe_out_if.source         out_ch
);

  // sequencer state
  i2cbe_pkg::cmd_t                  cmd;
  logic [i2cbe_pkg::IDX_W-1:0]      idx;
  logic [i2cbe_pkg::BYTE_W-1:0]     tx_sh;
  logic [i2cbe_pkg::BYTE_W-1:0]     rx_sh;
  logic                             ack_latch;
  logic                             scl;
  logic                             sda;
  logic                             drv;

  i2cbe_pkg::cmd_t                  cmd_next;
  logic [i2cbe_pkg::IDX_W-1:0]      idx_next;
  logic [i2cbe_pkg::BYTE_W-1:0]     tx_next;
  logic [i2cbe_pkg::BYTE_W-1:0]     rx_next;
  logic                             ack_next;
  logic                             scl_next;
  logic                             sda_next;
  logic                             drv_next;

  logic                             start;
  i2cbe_pkg::cmd_t                  c;
  logic [i2cbe_pkg::IDX_W-1:0]      p;
  logic [i2cbe_pkg::IDX_W-1:0]      pm1;
  logic [i2cbe_pkg::SH_W-1:0]       sh;
  logic                             busy;
  logic                             done;
  logic                             rej;
  logic [i2cbe_pkg::BYTE_W-1:0]     rx_out;
  logic                             ack_out;

  assign pop = not_empty && (!out_ch.valid || out_ch.ready);

  always_comb begin
    start   = (cmd == i2cbe_pkg::CMD_IDLE) && item.is_cmd;
    rej     = (cmd != i2cbe_pkg::CMD_IDLE) && item.is_cmd;
    c       = start ? item.cmd : cmd;
    p       = start ? '0 : idx;
    pm1     = p - i2cbe_pkg::IDX_W'(1);
    sh      = i2cbe_pkg::SH_W'(i2cbe_pkg::BITS_PER_BYTE - 1) - pm1[i2cbe_pkg::SH_W:1];

    tx_next = tx_sh;
    if (start && item.cmd == i2cbe_pkg::CMD_WRITE) begin
      tx_next = item.tx_byte;
    end else if (start && item.cmd == i2cbe_pkg::CMD_SNDACK) begin
      tx_next = i2cbe_pkg::BYTE_W'(item.ack_to_send);
    end
    rx_next = (start && item.cmd == i2cbe_pkg::CMD_READ) ? '0 : rx_sh;

    cmd_next = cmd;
    idx_next = idx;
    ack_next = ack_latch;
    scl_next = scl;
    sda_next = sda;
    drv_next = drv;
    busy     = 1'b0;
    done     = 1'b0;
    rx_out   = '0;
    ack_out  = 1'b0;

    if (c != i2cbe_pkg::CMD_IDLE) begin
      busy = 1'b1;
      case (c)
        i2cbe_pkg::CMD_START: begin
          drv_next = 1'b1;
          scl_next = (p < i2cbe_pkg::IDX_W'(2));
          sda_next = (p == '0);
        end
        i2cbe_pkg::CMD_STOP: begin
          drv_next = 1'b1;
          scl_next = (p != '0);
          sda_next = (p == i2cbe_pkg::IDX_W'(2));
        end
        i2cbe_pkg::CMD_WRITE: begin
          drv_next = 1'b1;
          if (p == '0) begin
            scl_next = 1'b0;
            sda_next = 1'b0;
          end else begin
            sda_next = tx_next[sh];
            scl_next = !p[0];
          end
        end
        i2cbe_pkg::CMD_RDACK: begin
          drv_next = 1'b0;
          if (p == '0) begin
            scl_next = 1'b1;
            ack_next = item.sda_in;
          end else begin
            scl_next = 1'b0;
          end
        end
        i2cbe_pkg::CMD_READ: begin
          drv_next = 1'b0;
          scl_next = p[0];
          if (p[0]) begin
            rx_next = {rx_next[i2cbe_pkg::BYTE_W-2:0], item.sda_in};
          end
        end
        default: begin
          drv_next = 1'b1;
          scl_next = (p == i2cbe_pkg::IDX_W'(2));
          sda_next = (p == '0) ? 1'b0 : tx_next[0];
        end
      endcase

      if ({1'b0, p} + 6'd1 >= {1'b0, i2cbe_pkg::cmd_len(c)}) begin
        done     = 1'b1;
        if (c == i2cbe_pkg::CMD_READ) begin
          rx_out = rx_next;
        end
        if (c == i2cbe_pkg::CMD_RDACK) begin
          ack_out = ack_next;
        end
        cmd_next = i2cbe_pkg::CMD_IDLE;
        idx_next = '0;
      end else begin
        cmd_next = c;
        idx_next = p + i2cbe_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd          <= i2cbe_pkg::CMD_IDLE;
      idx          <= '0;
      tx_sh        <= '0;
      rx_sh        <= '0;
      ack_latch    <= 1'b1;
      scl          <= 1'b1;
      sda          <= 1'b1;
      drv          <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (pop) begin
        cmd       <= cmd_next;
        idx       <= idx_next;
        tx_sh     <= tx_next;
        rx_sh     <= rx_next;
        ack_latch <= ack_next;
        scl       <= scl_next;
        sda       <= sda_next;
        drv       <= drv_next;
      end
      if (pop) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
    if (pop) begin
      out_ch.scl_level <= scl_next;
      out_ch.sda_level <= drv_next && sda_next;
      out_ch.sda_drive <= drv_next;
      out_ch.busy_res  <= busy;
      out_ch.done_res  <= done;
      out_ch.rx_byte   <= rx_out;
      out_ch.ack_seen  <= ack_out;
      out_ch.rejected  <= rej;
    end
  end

endmodule

// ===== design/i2c_master_bit_engine_top.sv =====
// Top level of the I2C master bit engine: decoder, request queue, sequencer.
// An accepted period request is written into the queue, then popped into the
//   sequencer, whose output register holds its result until it is taken.
// Throughput: one period per pop, so one per cycle while results are taken.
// Reset (rst, synchronous, active high): queue empty, no result pending,
//   sequencer idle with SCL and SDA levels high and SDA released.
module i2c_master_bit_engine_top (
  input  logic          clk,
  input  logic          rst,
  i2cbe_in_if.sink      in_ch,
  i2cbe_out_if.source   out_ch
);

  // Decoded period requests travel from the front end through a short queue,
  // so the sequencer can stall on the output side while the input keeps going.
  logic                push;
  logic                full;
  logic                pop;
  logic                not_empty;
  i2cbe_pkg::fe_item_t push_item;
  i2cbe_pkg::fe_item_t pop_item;

  // Accept a request and map its action code to a command (unused code = none).
  i2cbe_front u_front (
    .in_ch     (in_ch),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  // Hold up to two decoded requests.
  i2cbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_item  (pop_item)
  );

  // Advance the bus sequence one period per request; a command that arrives
  // mid-sequence is dropped and flagged, the running sequence keeps going.
  i2cbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .item      (pop_item),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  // A finished period always belongs to a running command.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.done_res |-> out_ch.busy_res)
    else $error("done without busy");

  // A rejected command means one was already running.
  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.rejected |-> out_ch.busy_res)
    else $error("rejected while idle");

  // Released SDA is reported low.
  a_sda_rel: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.sda_drive |-> !out_ch.sda_level)
    else $error("sda level set while released");

  // No result right after reset.
  a_rst_out: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule
